### rtl/dual_token_bucket_limiter_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the dual token bucket limiter
// Clocked on clock, disabled while reset is high, reported by $error.
// ----------------------------------------------------------------------------
`ifndef DUAL_TOKEN_BUCKET_LIMITER_ASSERT_SVH
`define DUAL_TOKEN_BUCKET_LIMITER_ASSERT_SVH

// same-cycle implication
`define DTBL_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("dual token bucket limiter: check failed");

// next-cycle implication
`define DTBL_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("dual token bucket limiter: check failed");

`endif

### rtl/dtbl_pkg.sv
// ----------------------------------------------------------------------------
// dtbl_pkg
// Widths, register indexes, controller states and command/status types.
// ----------------------------------------------------------------------------
package dtbl_pkg;

   localparam int NOW_W      = 48;
   localparam int OP_W       = 32;
   localparam int BYTE_W     = 40;
   localparam int LANE_W     = 40;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 40;

   localparam int NUM_LANES = 2;
   localparam int LANE_OP   = 0;
   localparam int LANE_BYTE = 1;

   // operands are fed to the multipliers in chunks; the chunks also cover now_us
   localparam int MUL_CHUNK_W = 16;
   localparam int MUL_CHUNKS  = 3;
   localparam int MUL_PAD_W   = MUL_CHUNK_W * MUL_CHUNKS;
   localparam int MUL_IDX_W   = $clog2(MUL_CHUNKS);

   localparam logic [CSR_IDX_W-1:0] CSR_OP_REFILL   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OP_MAX      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BYTE_REFILL = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BYTE_MAX    = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_MULTIPLY,
      ST_FILL,
      ST_DECIDE
   } dtbl_state_type;

   typedef struct packed {
      logic                 load;
      logic                 div_start;
      logic                 prep;
      logic                 mul_step;
      logic [MUL_IDX_W-1:0] mul_idx;
      logic                 fill;
      logic                 commit;
   } dtbl_cmd_type;

   typedef struct packed {
      logic due;
      logic bypass;
      logic div_done;
   } dtbl_status_type;

endpackage

### rtl/dtbl_if.sv
// ----------------------------------------------------------------------------
// dtbl_req_if / dtbl_rsp_if
// Valid/ready channels for requests and grant results.
// ----------------------------------------------------------------------------
interface dtbl_req_if;
   import dtbl_pkg::*;

   logic              valid;
   logic              ready;
   logic [NOW_W-1:0]  now_us;
   logic [OP_W-1:0]   op_count;
   logic [BYTE_W-1:0] byte_count;

   modport source (output valid, output now_us, output op_count, output byte_count,
                   input ready);
   modport sink   (input valid, input now_us, input op_count, input byte_count,
                   output ready);
endinterface

interface dtbl_rsp_if;
   logic valid;
   logic ready;
   logic granted;

   modport source (output valid, output granted, input ready);
   modport sink   (input valid, input granted, output ready);
endinterface

### rtl/dtbl_div.sv
// ----------------------------------------------------------------------------
// dtbl_div
// Divides the elapsed time by the refill period with a reciprocal multiply.
// ----------------------------------------------------------------------------
module dtbl_div #(
   parameter int REFILL_PERIOD_US = 100000
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   input  logic [dtbl_pkg::NOW_W-1:0]              dividend,
   output logic [dtbl_pkg::NOW_W-1:0]              quotient,
   output logic [$clog2(REFILL_PERIOD_US+1)-1:0]   remainder,
   output logic                                    done
);
   import dtbl_pkg::*;

   localparam int PW      = $clog2(REFILL_PERIOD_US + 1);
   localparam int SHIFT   = $clog2(REFILL_PERIOD_US);
   localparam int RECIP_W = NOW_W + 1;
   localparam int SCALE_W = NOW_W + SHIFT + 2;
   localparam int ACC_W   = MUL_CHUNK_W + RECIP_W + 1;

   // floor(2^(48+SHIFT) / period) + 1 is exact for every 48-bit dividend
   localparam logic [SCALE_W-1:0] SCALE      = SCALE_W'(1) << (NOW_W + SHIFT);
   localparam logic [SCALE_W-1:0] RECIP_WIDE = SCALE / SCALE_W'(REFILL_PERIOD_US)
                                               + SCALE_W'(1);
   localparam logic [RECIP_W-1:0] RECIP      = RECIP_W'(RECIP_WIDE);
   localparam logic [PW-1:0]      PERIOD_LOW = PW'(REFILL_PERIOD_US);

   logic [NOW_W-1:0]               num_ff, num_in;
   logic [PW-1:0]                  low_ff, low_in;
   logic [ACC_W-1:0]               acc_ff, acc_in;
   logic [MUL_IDX_W-1:0]           idx_ff, idx_in;
   logic                           busy_ff, busy_in;
   logic                           fin_ff, fin_in;
   logic                           done_ff;
   logic [NOW_W-1:0]               quo_ff, quo_in;
   logic [PW-1:0]                  rem_ff, rem_in;
   logic [MUL_CHUNK_W-1:0]         chunk;
   logic [MUL_CHUNK_W+RECIP_W-1:0] prod;
   logic [ACC_W-1:0]               step_sum;
   logic [NOW_W-1:0]               quo_v;
   logic [PW-1:0]                  low_prod;

   // least significant chunk first; drop the finished low bits each step
   assign chunk    = num_ff[MUL_CHUNK_W-1:0];
   assign prod     = chunk * RECIP;
   assign step_sum = acc_ff + ACC_W'(prod);

   // the remainder is below the period, so its low bits are enough
   assign quo_v    = NOW_W'(acc_ff >> SHIFT);
   assign low_prod = quo_v[PW-1:0] * PERIOD_LOW;

   always_comb begin
      num_in  = num_ff;
      low_in  = low_ff;
      acc_in  = acc_ff;
      idx_in  = idx_ff;
      busy_in = busy_ff;
      fin_in  = 1'b0;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      if (start) begin
         num_in  = dividend;
         low_in  = dividend[PW-1:0];
         acc_in  = '0;
         idx_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = num_ff >> MUL_CHUNK_W;
         acc_in = step_sum >> MUL_CHUNK_W;
         idx_in = idx_ff + 1'b1;
         if (idx_ff == MUL_IDX_W'(MUL_CHUNKS - 1)) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end
      end
      if (fin_ff) begin
         quo_in = quo_v;
         rem_in = low_ff - low_prod;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff  <= '0;
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         idx_ff  <= idx_in;
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
         done_ff <= fin_ff;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      low_ff <= low_in;
      acc_ff <= acc_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign quotient  = quo_ff;
   assign remainder = rem_ff;
   assign done      = done_ff;

endmodule

### rtl/dtbl_datapath.sv
// ----------------------------------------------------------------------------
// dtbl_datapath
// Registers, bucket state, deadline update, refill multiply and grant check.
// ----------------------------------------------------------------------------
module dtbl_datapath #(
   parameter int REFILL_PERIOD_US = 100000
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_en,
   input  logic [dtbl_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [dtbl_pkg::CSR_DATA_W-1:0] csr_write_data,
   input  logic [dtbl_pkg::NOW_W-1:0]      req_now_us,
   input  logic [dtbl_pkg::OP_W-1:0]       req_op_count,
   input  logic [dtbl_pkg::BYTE_W-1:0]     req_byte_count,
   input  dtbl_pkg::dtbl_cmd_type          cmd,
   output dtbl_pkg::dtbl_status_type       status,
   output logic                            rsp_granted
);
   import dtbl_pkg::*;

   localparam int PW = $clog2(REFILL_PERIOD_US + 1);
   localparam logic [NOW_W:0] PERIOD_EXT = (NOW_W + 1)'(REFILL_PERIOD_US);
   localparam int MSUM_W = MUL_CHUNK_W + LANE_W + 1;

   // configuration
   logic [OP_W-1:0]   op_refill_ff, op_refill_in;
   logic [OP_W-1:0]   op_max_ff, op_max_in;
   logic [BYTE_W-1:0] byte_refill_ff, byte_refill_in;
   logic [BYTE_W-1:0] byte_max_ff, byte_max_in;

   // limiter state
   logic [NOW_W-1:0]  next_refill_ff, next_refill_in;
   logic [OP_W-1:0]   op_tokens_ff, op_tokens_in;
   logic [BYTE_W-1:0] byte_tokens_ff, byte_tokens_in;

   // per-request working registers
   logic [NOW_W-1:0]  now_ff, now_in;
   logic [OP_W-1:0]   op_cnt_ff, op_cnt_in;
   logic [BYTE_W-1:0] byte_cnt_ff, byte_cnt_in;
   logic              refill_ff, refill_in;
   logic              bypass_ff, bypass_in;
   logic [NOW_W-1:0]  deadline_ff, deadline_in;
   logic [LANE_W-1:0] periods_ff, periods_in;
   logic              granted_ff, granted_in;

   logic [LANE_W-1:0] lvl_ff [NUM_LANES];
   logic [LANE_W-1:0] lvl_in [NUM_LANES];
   logic [LANE_W-1:0] acc_ff [NUM_LANES];
   logic [LANE_W-1:0] acc_in [NUM_LANES];
   logic              ovf_ff [NUM_LANES];
   logic              ovf_in [NUM_LANES];

   // lane views and combinational results
   logic [LANE_W-1:0]             rate   [NUM_LANES];
   logic [LANE_W-1:0]             cap    [NUM_LANES];
   logic [LANE_W-1:0]             cnt    [NUM_LANES];
   logic [MUL_CHUNK_W+LANE_W-1:0] prod   [NUM_LANES];
   logic [MSUM_W-1:0]             msum   [NUM_LANES];
   logic [LANE_W:0]               fsum   [NUM_LANES];
   logic [LANE_W-1:0]             filled [NUM_LANES];
   logic [LANE_W-1:0]             debit  [NUM_LANES];
   logic [NUM_LANES-1:0]          lim;
   logic [NUM_LANES-1:0]          fit;
   logic                          ok;

   logic [MUL_PAD_W-1:0]   periods_pad;
   logic [MUL_CHUNK_W-1:0] chunk;
   logic [NOW_W:0]         dsum;

   logic [NOW_W-1:0] quotient;
   logic [PW-1:0]    remainder;
   logic             div_done;

   dtbl_div #(
      .REFILL_PERIOD_US(REFILL_PERIOD_US)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (req_now_us - next_refill_ff),
      .quotient  (quotient),
      .remainder (remainder),
      .done      (div_done)
   );

   assign status.due      = req_now_us >= next_refill_ff;
   assign status.bypass   = (op_refill_ff == '0) && (byte_refill_ff == '0);
   assign status.div_done = div_done;

   // register writes
   always_comb begin
      op_refill_in   = op_refill_ff;
      op_max_in      = op_max_ff;
      byte_refill_in = byte_refill_ff;
      byte_max_in    = byte_max_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_OP_REFILL:   op_refill_in   = csr_write_data[OP_W-1:0];
            CSR_OP_MAX:      op_max_in      = csr_write_data[OP_W-1:0];
            CSR_BYTE_REFILL: byte_refill_in = csr_write_data[BYTE_W-1:0];
            CSR_BYTE_MAX:    byte_max_in    = csr_write_data[BYTE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      rate[LANE_OP]   = LANE_W'(op_refill_ff);
      rate[LANE_BYTE] = byte_refill_ff;
      cap[LANE_OP]    = LANE_W'(op_max_ff);
      cap[LANE_BYTE]  = byte_max_ff;
      cnt[LANE_OP]    = LANE_W'(op_cnt_ff);
      cnt[LANE_BYTE]  = byte_cnt_ff;
   end

   // multiply chunk, most significant first
   assign periods_pad = MUL_PAD_W'(periods_ff);
   assign chunk = periods_pad[(MUL_CHUNKS - 1 - int'(cmd.mul_idx)) * MUL_CHUNK_W +: MUL_CHUNK_W];

   always_comb begin
      for (int l = 0; l < NUM_LANES; l++) begin
         prod[l]   = chunk * rate[l];
         msum[l]   = {1'b0, acc_ff[l], {MUL_CHUNK_W{1'b0}}} + MSUM_W'(prod[l]);
         fsum[l]   = {1'b0, lvl_ff[l]} + {1'b0, acc_ff[l]};
         filled[l] = ((lvl_ff[l] >= cap[l]) || ovf_ff[l] || (fsum[l] > {1'b0, cap[l]}))
                     ? cap[l] : fsum[l][LANE_W-1:0];
         lim[l]    = rate[l] != '0;
         fit[l]    = cnt[l] <= lvl_ff[l];
         debit[l]  = lvl_ff[l] - cnt[l];
      end
   end

   assign ok = &(~lim | fit);

   // new deadline: now - (elapsed mod period) + period, clamped at end of time
   assign dsum = {1'b0, now_ff} - (NOW_W + 1)'(remainder) + PERIOD_EXT;

   always_comb begin
      now_in      = now_ff;
      op_cnt_in   = op_cnt_ff;
      byte_cnt_in = byte_cnt_ff;
      refill_in   = refill_ff;
      bypass_in   = bypass_ff;
      deadline_in = deadline_ff;
      periods_in  = periods_ff;
      granted_in  = granted_ff;
      lvl_in      = lvl_ff;
      acc_in      = acc_ff;
      ovf_in      = ovf_ff;
      if (cmd.load) begin
         now_in          = req_now_us;
         op_cnt_in       = req_op_count;
         byte_cnt_in     = req_byte_count;
         refill_in       = status.due && !status.bypass;
         bypass_in       = status.bypass;
         lvl_in[LANE_OP]   = LANE_W'(op_tokens_ff);
         lvl_in[LANE_BYTE] = byte_tokens_ff;
      end
      if (cmd.prep) begin
         // any count past the largest bucket saturates, so clamp it
         if ((quotient[NOW_W-1:LANE_W] != '0) || (&quotient[LANE_W-1:0])) begin
            periods_in = '1;
         end else begin
            periods_in = quotient[LANE_W-1:0] + 1'b1;
         end
         deadline_in = dsum[NOW_W] ? '1 : dsum[NOW_W-1:0];
         for (int l = 0; l < NUM_LANES; l++) begin
            acc_in[l] = '0;
            ovf_in[l] = 1'b0;
         end
      end
      if (cmd.mul_step) begin
         for (int l = 0; l < NUM_LANES; l++) begin
            acc_in[l] = msum[l][LANE_W-1:0];
            ovf_in[l] = ovf_ff[l] || (msum[l][MSUM_W-1:LANE_W] != '0);
         end
      end
      if (cmd.fill) begin
         lvl_in = filled;
      end
      if (cmd.commit) begin
         granted_in = bypass_ff || ok;
      end
   end

   always_comb begin
      next_refill_in = next_refill_ff;
      op_tokens_in   = op_tokens_ff;
      byte_tokens_in = byte_tokens_ff;
      if (cmd.commit && !bypass_ff) begin
         if (refill_ff) begin
            next_refill_in = deadline_ff;
         end
         op_tokens_in   = (ok && lim[LANE_OP]) ? OP_W'(debit[LANE_OP])
                                               : OP_W'(lvl_ff[LANE_OP]);
         byte_tokens_in = (ok && lim[LANE_BYTE]) ? debit[LANE_BYTE] : lvl_ff[LANE_BYTE];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_refill_ff   <= '0;
         op_max_ff      <= '0;
         byte_refill_ff <= '0;
         byte_max_ff    <= '0;
         next_refill_ff <= '0;
         op_tokens_ff   <= '0;
         byte_tokens_ff <= '0;
      end else begin
         op_refill_ff   <= op_refill_in;
         op_max_ff      <= op_max_in;
         byte_refill_ff <= byte_refill_in;
         byte_max_ff    <= byte_max_in;
         next_refill_ff <= next_refill_in;
         op_tokens_ff   <= op_tokens_in;
         byte_tokens_ff <= byte_tokens_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff      <= now_in;
      op_cnt_ff   <= op_cnt_in;
      byte_cnt_ff <= byte_cnt_in;
      refill_ff   <= refill_in;
      bypass_ff   <= bypass_in;
      deadline_ff <= deadline_in;
      periods_ff  <= periods_in;
      granted_ff  <= granted_in;
      lvl_ff      <= lvl_in;
      acc_ff      <= acc_in;
      ovf_ff      <= ovf_in;
   end

   assign rsp_granted = granted_ff;

endmodule

### rtl/dtbl_ctrl.sv
// ----------------------------------------------------------------------------
// dtbl_ctrl
// Sequencer: accept, divide, multiply, fill, decide; owns the result valid.
// ----------------------------------------------------------------------------
module dtbl_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output dtbl_pkg::dtbl_cmd_type    cmd,
   input  dtbl_pkg::dtbl_status_type status
);
   import dtbl_pkg::*;

   dtbl_state_type       state_ff, state_in;
   logic [MUL_IDX_W-1:0] mul_idx_ff, mul_idx_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 req_fire;
   logic                 out_free;
   logic                 mul_last;

   assign req_fire = req_valid && (state_ff == ST_IDLE);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign mul_last = mul_idx_ff == MUL_IDX_W'(MUL_CHUNKS - 1);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (!status.bypass && status.due) begin
                  state_in = ST_DIVIDE;
               end else begin
                  state_in = ST_DECIDE;
               end
            end
         end
         ST_DIVIDE: begin
            if (status.div_done) begin
               state_in = ST_MULTIPLY;
            end
         end
         ST_MULTIPLY: begin
            if (mul_last) begin
               state_in = ST_FILL;
            end
         end
         ST_FILL: state_in = ST_DECIDE;
         ST_DECIDE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd         = '0;
      cmd.mul_idx = mul_idx_ff;
      req_ready   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready     = 1'b1;
            cmd.load      = req_fire;
            cmd.div_start = req_fire && !status.bypass && status.due;
         end
         ST_DIVIDE:   cmd.prep     = status.div_done;
         ST_MULTIPLY: cmd.mul_step = 1'b1;
         ST_FILL:     cmd.fill     = 1'b1;
         ST_DECIDE:   cmd.commit   = out_free;
         default: ;
      endcase
   end

   always_comb begin
      mul_idx_in = mul_idx_ff;
      if (cmd.prep) begin
         mul_idx_in = '0;
      end else if (cmd.mul_step) begin
         mul_idx_in = mul_idx_ff + 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mul_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mul_idx_ff   <= mul_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

### rtl/dual_token_bucket_limiter.sv
// ----------------------------------------------------------------------------
// dual_token_bucket_limiter
// Admits or refuses requests against an operation bucket and a byte bucket.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus carries now_us, op_count and byte_count; rsp_bus returns one
//   granted bit per request, in order. csr_* writes refills and bucket
//   maximums; write them only while no request is outstanding.
// Timing:
//   When now_us has reached the refill deadline, an item goes from acceptance
//   to rsp valid through these steps: the divider (three 16 x 49 reciprocal
//   multiply steps, one to form quotient and remainder), one to form the
//   period count and deadline, three chunked 16 x 40 multiplies, one fill,
//   one decide. Otherwise, or with both refills zero, it goes straight from
//   acceptance to the decide step. One item is in work at a time; req ready
//   is high only between items, so a new item is taken only once the last
//   has left the decide step.
// Stall:
//   The result register holds granted while rsp ready is low; the next item
//   may be accepted and worked on, and waits in the decide step until the
//   result register is free.
// Reset:
//   Synchronous; clears the configuration registers, both buckets and the deadline to zero.
// ----------------------------------------------------------------------------
module dual_token_bucket_limiter #(
   parameter int REFILL_PERIOD_US = 100000
) (
   input  logic                            clock,
   input  logic                            reset,
   dtbl_req_if.sink                        req_bus,
   dtbl_rsp_if.source                      rsp_bus,
   input  logic                            csr_write_en,
   input  logic [dtbl_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [dtbl_pkg::CSR_DATA_W-1:0] csr_write_data
);
   import dtbl_pkg::*;

   dtbl_cmd_type    cmd;
   dtbl_status_type status;

   // sequencer: one item at a time, holds the result valid
   dtbl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd),
      .status    (status)
   );

   // registers, bucket levels, divider and multiply lanes
   dtbl_datapath #(
      .REFILL_PERIOD_US(REFILL_PERIOD_US)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .req_now_us     (req_bus.now_us),
      .req_op_count   (req_bus.op_count),
      .req_byte_count (req_bus.byte_count),
      .cmd            (cmd),
      .status         (status),
      .rsp_granted    (rsp_bus.granted)
   );

endmodule

### rtl/dtbl_checker.sv
// ----------------------------------------------------------------------------
// dtbl_checker
// Port-level checks on the limiter's handshakes and item accounting.
// ----------------------------------------------------------------------------
`include "dual_token_bucket_limiter_assert.svh"

module dtbl_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_granted
);
   logic [1:0] pending_ff, pending_in;
   logic       req_fire;
   logic       rsp_fire;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   // items accepted and not yet delivered
   always_comb begin
      pending_in = pending_ff;
      if (req_fire && !rsp_fire) begin
         pending_in = pending_ff + 1'b1;
      end else if (rsp_fire && !req_fire) begin
         pending_in = pending_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   `DTBL_ASSERT_NXT(a_rsp_valid_holds, rsp_valid && !rsp_ready, rsp_valid)
   `DTBL_ASSERT_NXT(a_rsp_data_holds, rsp_valid && !rsp_ready, $stable(rsp_granted))
   `DTBL_ASSERT_NXT(a_busy_after_accept, req_fire, !req_ready)
   `DTBL_ASSERT_IMP(a_rsp_has_item, rsp_valid, (pending_ff == 2'd1) || (pending_ff == 2'd2))

endmodule

bind dual_token_bucket_limiter dtbl_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_bus.valid),
   .req_ready   (req_bus.ready),
   .rsp_valid   (rsp_bus.valid),
   .rsp_ready   (rsp_bus.ready),
   .rsp_granted (rsp_bus.granted)
);
